/* hw/rtl/clct_pkg.sv */
// ----------------------------------------------------------------------------
// clct_pkg
// Shared types, codes and constants of the character-LCD command translator.
// ----------------------------------------------------------------------------
package clct_pkg;

  localparam int COLUMNS_DEF  = 20;
  localparam int ROWS_DEF     = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int MAP_ROWS_MAX = 4;

  localparam int BYTE_W       = 8;
  localparam int COL_W        = 6;
  localparam int ROW_W        = 2;
  localparam int SLOT_W       = 3;
  localparam int LANE_W       = 3;
  localparam int GLYPH_ROW_W  = 5;
  localparam int GLYPH_ADDR_W = 6;
  localparam int GLYPH_SLOTS  = 8;
  localparam int GLYPH_LANES  = 8;
  localparam int BITS_W       = GLYPH_ROW_W * GLYPH_LANES;
  localparam int ACT_W        = 3;
  localparam int M_TDATA_W    = 64;
  localparam int PAD_W        = M_TDATA_W - BITS_W - SLOT_W - BYTE_W - ROW_W - COL_W;

  // command byte patterns
  localparam logic [7:0] CMD_CLEAR      = 8'b0000_0001;
  localparam logic [7:0] CMD_HOME       = 8'b0000_001?;
  localparam logic [7:0] CMD_ENTRY      = 8'b0000_01??;
  localparam logic [7:0] CMD_DISPLAY    = 8'b0000_1???;
  localparam logic [7:0] CMD_SHIFT      = 8'b0001_????;
  localparam logic [7:0] CMD_FUNCTION   = 8'b001?_????;
  localparam logic [7:0] CMD_GLYPH_ADDR = 8'b01??_????;
  localparam logic [7:0] CMD_TEXT_ADDR  = 8'b1???_????;

  localparam int ENTRY_UP_BIT   = 1;
  localparam int DISPLAY_ON_BIT = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR,
    ACT_HOME,
    ACT_DISPLAY_ON,
    ACT_SET_CURSOR,
    ACT_WRITE_CHAR,
    ACT_LOAD_GLYPH
  } action_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_HOME,
    OP_ENTRY,
    OP_DISPLAY_ON,
    OP_TEXT_ADDR,
    OP_GLYPH_ADDR,
    OP_DATA
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] arg;
    logic              hit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } op_t;

  // lowest bits first: col, row, chr, slot, bits, pad
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [BITS_W-1:0] bits;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] chr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } out_data_t;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } bk_state_t;

  function automatic logic [7:0] row_offset(input int r);
    logic [7:0] off;
    case (r)
      0:       off = 8'h00;
      1:       off = 8'h40;
      2:       off = 8'h14;
      3:       off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

endpackage

/* hw/rtl/clct_front.sv */
// ----------------------------------------------------------------------------
// clct_front
// Accepts bus items, decodes commands and maps text addresses onto the screen.
// ----------------------------------------------------------------------------
module clct_front #(
  parameter int COLUMNS = clct_pkg::COLUMNS_DEF,
  parameter int ROWS    = clct_pkg::ROWS_DEF
) (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [clct_pkg::BYTE_W-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        q_full,
  output logic                        q_push,
  output clct_pkg::op_t               q_op
);

  localparam int MAP_ROWS = (ROWS < clct_pkg::MAP_ROWS_MAX) ? ROWS : clct_pkg::MAP_ROWS_MAX;

  logic                         keep;
  logic                         hit;
  logic [clct_pkg::ROW_W-1:0]   map_row;
  logic [clct_pkg::COL_W-1:0]   map_col;
  logic [6:0]                   addr;

  assign addr = s_axis_tdata[6:0];

  // lowest-numbered matching row wins
  always_comb begin
    hit     = 1'b0;
    map_row = '0;
    map_col = '0;
    for (int r = MAP_ROWS - 1; r >= 0; r--) begin
      if (int'(addr) >= int'(clct_pkg::row_offset(r)) &&
          int'(addr) < int'(clct_pkg::row_offset(r)) + COLUMNS) begin
        hit     = 1'b1;
        map_row = clct_pkg::ROW_W'(r);
        map_col = clct_pkg::COL_W'({1'b0, addr} - clct_pkg::row_offset(r));
      end
    end
  end

  always_comb begin
    keep      = 1'b0;
    q_op.kind = clct_pkg::OP_DATA;
    q_op.arg  = s_axis_tdata;
    q_op.hit  = hit;
    q_op.row  = map_row;
    q_op.col  = map_col;
    if (s_axis_tuser) begin
      keep = 1'b1;
    end else begin
      case (s_axis_tdata) inside
        clct_pkg::CMD_CLEAR: begin
          keep      = 1'b1;
          q_op.kind = clct_pkg::OP_CLEAR;
        end
        clct_pkg::CMD_HOME: begin
          keep      = 1'b1;
          q_op.kind = clct_pkg::OP_HOME;
        end
        clct_pkg::CMD_ENTRY: begin
          keep      = 1'b1;
          q_op.kind = clct_pkg::OP_ENTRY;
        end
        clct_pkg::CMD_DISPLAY: begin
          keep      = s_axis_tdata[clct_pkg::DISPLAY_ON_BIT];
          q_op.kind = clct_pkg::OP_DISPLAY_ON;
        end
        clct_pkg::CMD_SHIFT, clct_pkg::CMD_FUNCTION: begin
          keep = 1'b0;
        end
        clct_pkg::CMD_TEXT_ADDR: begin
          keep      = 1'b1;
          q_op.kind = clct_pkg::OP_TEXT_ADDR;
        end
        clct_pkg::CMD_GLYPH_ADDR: begin
          keep      = 1'b1;
          q_op.kind = clct_pkg::OP_GLYPH_ADDR;
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

/* hw/rtl/clct_queue.sv */
// ----------------------------------------------------------------------------
// clct_queue
// Short queue of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module clct_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  clct_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output clct_pkg::op_t head_op
);

  localparam int DEPTH = clct_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  clct_pkg::op_t      entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/clct_back.sv */
// ----------------------------------------------------------------------------
// clct_back
// Carries out decoded operations: cursor, entry direction and glyph store,
// and drives the result register.
// ----------------------------------------------------------------------------
module clct_back #(
  parameter int COLUMNS = clct_pkg::COLUMNS_DEF,
  parameter int ROWS    = clct_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  clct_pkg::op_t                  head_op,
  output logic                           pop,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [clct_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [clct_pkg::ACT_W-1:0]     m_axis_tuser,
  output logic                           m_axis_tlast
);

  clct_pkg::bk_state_t state, state_next;

  logic                                 count_up;
  logic                                 glyph_mode;
  logic [clct_pkg::GLYPH_ADDR_W-1:0]    glyph_address;
  logic [clct_pkg::ROW_W-1:0]           row_now;
  logic [clct_pkg::COL_W-1:0]           column_now;
  logic [clct_pkg::GLYPH_SLOTS-1:0][clct_pkg::GLYPH_LANES-1:0][clct_pkg::GLYPH_ROW_W-1:0]
                                        glyph_rows;
  logic [clct_pkg::GLYPH_LANES-1:0][clct_pkg::GLYPH_ROW_W-1:0] glyph_merged;
  logic [clct_pkg::SLOT_W-1:0]          gslot;
  logic [clct_pkg::LANE_W-1:0]          glane;

  logic                  load_ok;
  logic                  step;
  logic                  emit;
  logic                  res_last;
  clct_pkg::action_t     res_act;
  clct_pkg::out_data_t   res_data;

  assign load_ok = !m_axis_tvalid || m_axis_tready;
  assign step    = head_valid && load_ok;
  assign gslot   = glyph_address[clct_pkg::GLYPH_ADDR_W-1 -: clct_pkg::SLOT_W];
  assign glane   = glyph_address[clct_pkg::LANE_W-1:0];

  always_comb begin
    glyph_merged        = glyph_rows[gslot];
    glyph_merged[glane] = head_op.arg[clct_pkg::GLYPH_ROW_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      clct_pkg::BK_FIRST: begin
        if (step && (head_op.kind == clct_pkg::OP_CLEAR ||
                     (head_op.kind == clct_pkg::OP_DATA && !glyph_mode))) begin
          state_next = clct_pkg::BK_SECOND;
        end
      end
      clct_pkg::BK_SECOND: begin
        if (step) begin
          state_next = clct_pkg::BK_FIRST;
        end
      end
      default: state_next = clct_pkg::BK_FIRST;
    endcase
  end

  // outputs
  always_comb begin
    emit     = 1'b0;
    res_last = 1'b0;
    res_act  = clct_pkg::ACT_CLEAR;
    res_data = '0;
    pop      = 1'b0;
    if (step) begin
      case (head_op.kind)
        clct_pkg::OP_CLEAR: begin
          emit = 1'b1;
          if (state == clct_pkg::BK_FIRST) begin
            res_act = clct_pkg::ACT_CLEAR;
          end else begin
            res_act  = clct_pkg::ACT_HOME;
            res_last = 1'b1;
            pop      = 1'b1;
          end
        end
        clct_pkg::OP_HOME: begin
          emit     = 1'b1;
          res_act  = clct_pkg::ACT_HOME;
          res_last = 1'b1;
          pop      = 1'b1;
        end
        clct_pkg::OP_DISPLAY_ON: begin
          emit     = 1'b1;
          res_act  = clct_pkg::ACT_DISPLAY_ON;
          res_last = 1'b1;
          pop      = 1'b1;
        end
        clct_pkg::OP_TEXT_ADDR: begin
          emit         = head_op.hit;
          res_act      = clct_pkg::ACT_SET_CURSOR;
          res_last     = 1'b1;
          res_data.col = head_op.col;
          res_data.row = head_op.row;
          pop          = 1'b1;
        end
        clct_pkg::OP_DATA: begin
          emit = 1'b1;
          if (glyph_mode) begin
            res_act       = clct_pkg::ACT_LOAD_GLYPH;
            res_last      = 1'b1;
            res_data.slot = gslot;
            res_data.bits = glyph_merged;
            pop           = 1'b1;
          end else if (state == clct_pkg::BK_FIRST) begin
            res_act      = clct_pkg::ACT_SET_CURSOR;
            res_data.col = column_now;
            res_data.row = row_now;
          end else begin
            res_act      = clct_pkg::ACT_WRITE_CHAR;
            res_last     = 1'b1;
            res_data.chr = head_op.arg;
            pop          = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= clct_pkg::BK_FIRST;
      m_axis_tvalid <= 1'b0;
      count_up      <= 1'b1;
      glyph_mode    <= 1'b0;
      glyph_address <= '0;
      row_now       <= '0;
      column_now    <= '0;
      glyph_rows    <= '0;
    end else begin
      state <= state_next;
      if (load_ok) begin
        m_axis_tvalid <= emit;
      end
      if (pop) begin
        case (head_op.kind)
          clct_pkg::OP_CLEAR, clct_pkg::OP_HOME: begin
            glyph_mode <= 1'b0;
            row_now    <= '0;
            column_now <= '0;
          end
          clct_pkg::OP_ENTRY: begin
            count_up <= head_op.arg[clct_pkg::ENTRY_UP_BIT];
          end
          clct_pkg::OP_TEXT_ADDR: begin
            glyph_mode <= 1'b0;
            if (head_op.hit) begin
              row_now    <= head_op.row;
              column_now <= head_op.col;
            end
          end
          clct_pkg::OP_GLYPH_ADDR: begin
            glyph_mode    <= 1'b1;
            glyph_address <= head_op.arg[clct_pkg::GLYPH_ADDR_W-1:0];
          end
          clct_pkg::OP_DATA: begin
            if (glyph_mode) begin
              glyph_rows[gslot] <= glyph_merged;
              glyph_address     <= count_up ? glyph_address + 1'b1 : glyph_address - 1'b1;
            end else if (count_up) begin
              if (column_now >= clct_pkg::COL_W'(COLUMNS - 1)) begin
                column_now <= '0;
                row_now    <= (row_now >= clct_pkg::ROW_W'(ROWS - 1)) ? '0 : row_now + 1'b1;
              end else begin
                column_now <= column_now + 1'b1;
              end
            end else if (column_now == '0) begin
              column_now <= clct_pkg::COL_W'(COLUMNS - 1);
              row_now    <= (row_now == '0) ? clct_pkg::ROW_W'(ROWS - 1) : row_now - 1'b1;
            end else begin
              column_now <= column_now - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && emit) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= res_act;
      m_axis_tlast <= res_last;
    end
  end

endmodule

/* hw/rtl/char_lcd_command_translator.sv */
// ----------------------------------------------------------------------------
// char_lcd_command_translator
// Turns character-LCD bus writes into logical display actions.
// ----------------------------------------------------------------------------
// An accepted item goes into the two-entry queue; its first result is
// then registered at the output. Throughput: one item per cycle while the
// queue is not full; the back end produces one result per cycle while the
// output is not stalled; two-result items use BK_FIRST then BK_SECOND.
// Reset: synchronous; clears queue, cursor, glyph state and glyph store.
module char_lcd_command_translator #(
  parameter int COLUMNS = clct_pkg::COLUMNS_DEF,
  parameter int ROWS    = clct_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [clct_pkg::BYTE_W-1:0]    s_axis_tdata,  // bus_byte
  input  logic                           s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cursor_column[5:0], cursor_row[7:6], char_code[15:8], glyph_slot[18:16],
  // glyph_bits[58:19], zero[63:59]
  output logic [clct_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [clct_pkg::ACT_W-1:0]     m_axis_tuser,  // action
  output logic                           m_axis_tlast   // last
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_head_valid;
  clct_pkg::op_t q_op;
  clct_pkg::op_t q_head;

  clct_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (q_op)
  );

  clct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_op    (q_head)
  );

  clct_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head_op       (q_head),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hw/rtl/clct_checker.sv */
// ----------------------------------------------------------------------------
// clct_checker
// Port-level checks on the translator's result stream.
// ----------------------------------------------------------------------------
module clct_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [clct_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [clct_pkg::ACT_W-1:0]     m_axis_tuser,
  input logic                           m_axis_tlast
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_clear_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == clct_pkg::ACT_CLEAR |-> !m_axis_tlast)
    else $error("clear marked last");

  a_char_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == clct_pkg::ACT_WRITE_CHAR |-> m_axis_tlast)
    else $error("write_char not marked last");

  a_cursor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != clct_pkg::ACT_SET_CURSOR |-> m_axis_tdata[7:0] == '0)
    else $error("cursor fields set outside set_cursor");

endmodule

bind char_lcd_command_translator clct_checker u_clct_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the character-LCD command translator. Bus writes go in on the
// slave stream; a local model of the decoder (entry direction, text cursor,
// glyph address and glyph store) predicts every display action, and each
// action leaving the master stream is checked against the oldest prediction.
// Directed writes cover every command class, cursor wrap both ways, off-screen
// addresses and glyph address wrap; random traffic follows in four phases of
// source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCOLS      = 20;
  localparam int NROWS      = 4;
  localparam int HANG_LIMIT = 4000;
  localparam int DRAIN_CYC  = 8;

  localparam logic [7:0] CLEAR_BYTE = 8'h01;
  localparam logic [7:0] HOME_MASK  = 8'hFE;
  localparam logic [7:0] HOME_BYTE  = 8'h02;
  localparam logic [7:0] ENTRY_MASK = 8'hFC;
  localparam logic [7:0] ENTRY_BYTE = 8'h04;
  localparam logic [7:0] DISP_MASK  = 8'hF8;
  localparam logic [7:0] DISP_BYTE  = 8'h08;
  localparam logic [7:0] SHIFT_MASK = 8'hF0;
  localparam logic [7:0] SHIFT_BYTE = 8'h10;
  localparam logic [7:0] FSET_MASK  = 8'hE0;
  localparam logic [7:0] FSET_BYTE  = 8'h20;
  localparam logic [7:0] TEXT_ADDR  = 8'h80;
  localparam logic [7:0] GLYPH_ADDR = 8'h40;
  localparam int         TEXT_BIT   = 7;
  localparam int         GLYPH_BIT  = 6;
  localparam logic       CMD        = 1'b0;
  localparam logic       DAT        = 1'b1;

  typedef struct {
    clct_pkg::action_t   act;
    clct_pkg::out_data_t d;
    logic                last;
  } lcd_result_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int mismatches    = 0;
  int live_writes   = 0;
  int quiet_cycles  = 0;

  // predicted decoder state
  logic       count_up   = 1'b1;
  logic       glyph_mode = 1'b0;
  logic [5:0] glyph_addr = '0;
  logic [1:0] row_now    = '0;
  logic [5:0] col_now    = '0;
  logic [4:0] glyph_store [64];

  lcd_result_t pending_actions [$];

  char_lcd_command_translator #(.COLUMNS(NCOLS), .ROWS(NROWS)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk = ~clk;

  initial begin
    for (int i = 0; i < 64; i++) glyph_store[i] = '0;
  end

  function automatic int text_row_base(input int r);
    case (r)
      0: return 'h00;
      1: return 'h40;
      2: return 'h14;
      default: return 'h54;
    endcase
  endfunction

  task automatic push_action(input clct_pkg::action_t a, input logic [5:0] c,
                             input logic [1:0] r, input logic [7:0] ch,
                             input logic [2:0] sl, input logic [39:0] rows,
                             input logic lst);
    lcd_result_t e;
    e.act    = a;
    e.d      = '0;
    e.d.col  = c;
    e.d.row  = r;
    e.d.chr  = ch;
    e.d.slot = sl;
    e.d.bits = rows;
    e.last   = lst;
    pending_actions.push_back(e);
  endtask

  task automatic advance_cursor();
    if (count_up) begin
      if (col_now == NCOLS - 1) begin
        col_now = '0;
        row_now = (row_now == NROWS - 1) ? 2'd0 : row_now + 2'd1;
      end else begin
        col_now = col_now + 6'd1;
      end
    end else if (col_now == 0) begin
      col_now = 6'(NCOLS - 1);
      row_now = (row_now == 0) ? 2'(NROWS - 1) : row_now - 2'd1;
    end else begin
      col_now = col_now - 6'd1;
    end
  endtask

  task automatic translate_write(input logic func, input logic [7:0] b);
    logic [39:0] rows;
    int          a;
    int          base;
    bit          hit;
    hit = 1'b0;
    live_writes++;
    if (func) begin
      if (glyph_mode) begin
        glyph_store[glyph_addr] = b[4:0];
        rows = '0;
        for (int i = 0; i < 8; i++) rows[5*i +: 5] = glyph_store[glyph_addr[5:3]*8 + i];
        push_action(clct_pkg::ACT_LOAD_GLYPH, '0, '0, '0, glyph_addr[5:3], rows, 1'b1);
        glyph_addr = count_up ? glyph_addr + 6'd1 : glyph_addr - 6'd1;
      end else begin
        push_action(clct_pkg::ACT_SET_CURSOR, col_now, row_now, '0, '0, '0, 1'b0);
        push_action(clct_pkg::ACT_WRITE_CHAR, '0, '0, b, '0, '0, 1'b1);
        advance_cursor();
      end
    end else if (b == CLEAR_BYTE) begin
      glyph_mode = 1'b0;
      row_now    = '0;
      col_now    = '0;
      push_action(clct_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0);
      push_action(clct_pkg::ACT_HOME, '0, '0, '0, '0, '0, 1'b1);
    end else if ((b & HOME_MASK) == HOME_BYTE) begin
      glyph_mode = 1'b0;
      row_now    = '0;
      col_now    = '0;
      push_action(clct_pkg::ACT_HOME, '0, '0, '0, '0, '0, 1'b1);
    end else if ((b & ENTRY_MASK) == ENTRY_BYTE) begin
      count_up = b[clct_pkg::ENTRY_UP_BIT];
    end else if ((b & DISP_MASK) == DISP_BYTE) begin
      if (b[clct_pkg::DISPLAY_ON_BIT])
        push_action(clct_pkg::ACT_DISPLAY_ON, '0, '0, '0, '0, '0, 1'b1);
      else live_writes--;
    end else if ((b & SHIFT_MASK) == SHIFT_BYTE || (b & FSET_MASK) == FSET_BYTE) begin
      live_writes--;
    end else if (b[TEXT_BIT]) begin
      glyph_mode = 1'b0;
      a = b[6:0];
      for (int r = 0; r < NROWS; r++) begin
        base = text_row_base(r);
        if (!hit && a >= base && a < base + NCOLS) begin
          hit     = 1'b1;
          row_now = 2'(r);
          col_now = 6'(a - base);
          push_action(clct_pkg::ACT_SET_CURSOR, col_now, row_now, '0, '0, '0, 1'b1);
        end
      end
    end else if (b[GLYPH_BIT]) begin
      glyph_mode = 1'b1;
      glyph_addr = b[5:0];
    end else begin
      live_writes--;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_write(input logic func, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    translate_write(func, b);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    lcd_result_t         e;
    clct_pkg::out_data_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected action %0d data %h last %b", m_axis_tuser, m_axis_tdata,
                   m_axis_tlast);
      end else begin
        e = pending_actions.pop_front();
        if (m_axis_tuser !== e.act || got.col !== e.d.col || got.row !== e.d.row ||
            got.chr !== e.d.chr || got.slot !== e.d.slot || got.bits !== e.d.bits ||
            got.pad !== e.d.pad || m_axis_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp act %0d col %0d row %0d chr %h slot %0d bits %h last %b",
                     e.act, e.d.col, e.d.row, e.d.chr, e.d.slot, e.d.bits, e.last);
            $display("  got act %0d col %0d row %0d chr %h slot %0d bits %h pad %h last %b",
                     m_axis_tuser, got.col, got.row, got.chr, got.slot, got.bits, got.pad,
                     m_axis_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_commands();
    send_write(CMD, 8'h00);
    send_write(CMD, CLEAR_BYTE);
    send_write(CMD, 8'h03);
    send_write(CMD, 8'h02);
    send_write(CMD, 8'h08);
    send_write(CMD, 8'h0C);
    send_write(CMD, 8'h0F);
    send_write(CMD, 8'h10);
    send_write(CMD, 8'h3F);
    send_write(CMD, 8'hA8);
    send_write(CMD, 8'hFF);
  endtask

  task automatic test_text_writes();
    send_write(DAT, 8'h41);
    send_write(CMD, 8'h93);
    send_write(DAT, 8'hFF);
    send_write(CMD, 8'hE7);
    send_write(DAT, 8'h00);
    send_write(CMD, 8'h04);
    send_write(CMD, 8'h80);
    send_write(DAT, 8'h55);
    send_write(DAT, 8'hAA);
  endtask

  task automatic test_glyph_loads();
    send_write(CMD, 8'h40);
    send_write(DAT, 8'h1F);
    send_write(DAT, 8'hE0);
    send_write(CMD, 8'h07);
    send_write(CMD, 8'h7F);
    send_write(DAT, 8'h15);
    send_write(DAT, 8'h0A);
    send_write(CMD, 8'hC0);
    send_write(DAT, 8'h7E);
  endtask

  task automatic test_random_traffic(input int src, input int snk, input int n);
    int start;
    int pick;
    int len;
    int r;
    start         = live_writes;
    src_idle_pct  = src;
    snk_stall_pct = snk;
    while (live_writes - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 2) == 0) send_write(CMD, ENTRY_BYTE | 8'($urandom_range(0, 3)));
        if ($urandom_range(0, 4) != 0) begin
          r = $urandom_range(0, NROWS - 1);
          send_write(CMD, TEXT_ADDR | 8'(text_row_base(r) + $urandom_range(0, NCOLS - 1)));
        end else begin
          send_write(CMD, TEXT_ADDR | 8'($urandom_range(0, 127)));
        end
        len = $urandom_range(1, 25);
        repeat (len) send_write(DAT, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        if ($urandom_range(0, 2) == 0) send_write(CMD, ENTRY_BYTE | 8'($urandom_range(0, 3)));
        send_write(CMD, GLYPH_ADDR | 8'($urandom_range(0, 63)));
        len = $urandom_range(1, 10);
        repeat (len) send_write(DAT, 8'($urandom_range(0, 255)));
      end else begin
        send_write(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_commands();
    test_text_writes();
    test_glyph_loads();
    test_random_traffic(0, 0, 225);
    test_random_traffic(80, 0, 225);
    test_random_traffic(0, 80, 225);
    test_random_traffic(12, 12, 225);
    s_axis_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* char_lcd_command_translator.f */
hw/rtl/clct_pkg.sv
hw/rtl/clct_front.sv
hw/rtl/clct_queue.sv
hw/rtl/clct_back.sv
hw/rtl/char_lcd_command_translator.sv
hw/rtl/clct_checker.sv
bench/tb.sv
